// File: sv/fas_pkg.sv
// ---------------------------------------------------------------------------
// fas_pkg
// Shared constants and types for the single-precision add/subtract core.
// ---------------------------------------------------------------------------
package fas_pkg;

  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned AccW   = 27;
  localparam int unsigned AlignLim = 24;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // stage 1 -> stage 2: aligned operands
  typedef struct packed {
    logic            pass;
    logic [31:0]     pass_word;
    logic            sign;
    logic [ExpW-1:0] le;
    logic            sub;
    logic [AccW-1:0] lw;
    logic [AccW-1:0] sw;
  } align_t;

  // stage 2 -> stage 3: sum and leading-one position
  typedef struct packed {
    logic            pass;
    logic [31:0]     pass_word;
    logic            sign;
    logic [ExpW-1:0] le;
    logic [AccW-1:0] acc;
    logic            found;
    logic [4:0]      top;
  } norm_t;

endpackage

// File: sv/float32_add_sub_core.sv
// ---------------------------------------------------------------------------
// float32_add_sub_core
// Single-precision add/subtract, three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: op_i, operand_a_i, operand_b_i with in_valid_i/in_ready_o.
//   op_i = 0 adds, op_i = 1 subtracts operand_b_i from operand_a_i.
//   Output channel: sum_bits_o with out_valid_o/out_ready_i.
//   One beat can enter every cycle while the output is not stalled.
//   Stage 1 orders and aligns, stage 2 adds and finds the leading one,
//   stage 3 normalises, rounds and packs into the output register.
//   When the receiver stalls, the pipeline holds; stages advance only into
//   empty slots, so in_ready_o drops once every stage is full.
//   Reset clears all valid bits; no result is pending after reset.
//   Rounding is half-up on the first dropped bit without sticky; overflow
//   gives infinity and underflow a signed zero.
// ---------------------------------------------------------------------------
module float32_add_sub_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  fas_pkg::align_t s1_d, s1_q;
  fas_pkg::norm_t  s2_d, s2_q;
  logic [31:0]     s3_d, s3_q;

  // backpressure chain
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: order, align
  logic [31:0] b, lead, minor;
  logic [7:0]  le, se, shift;
  logic [23:0] sp;
  logic [26:0] sw;
  always_comb begin
    b = {operand_b_i[31] ^ op_i, operand_b_i[30:0]};
    if (operand_a_i[30:0] >= b[30:0]) begin
      lead = operand_a_i; minor = b;
    end else begin
      lead = b; minor = operand_a_i;
    end
    le    = lead[30:23];
    se    = minor[30:23];
    shift = le - se;
    sp    = (se == 8'd0) ? 24'd0 : {1'b1, minor[22:0]};
    if (shift >= 8'(fas_pkg::AlignLim))  sw = '0;
    else if (shift >= 8'd2)              sw = 27'(sp >> (shift - 8'd2));
    else                                 sw = 27'(sp) << (8'd2 - shift);
    s1_d.pass      = (le == fas_pkg::ExpMax);
    s1_d.pass_word = lead;
    s1_d.sign      = lead[31];
    s1_d.le        = le;
    s1_d.sub       = lead[31] ^ minor[31];
    s1_d.lw        = {2'b01, lead[22:0], 2'b00};
    s1_d.sw        = sw;
  end

  // stage 2: add, leading-one search
  logic [26:0] acc;
  always_comb begin
    acc = s1_q.sub ? s1_q.lw - s1_q.sw : s1_q.lw + s1_q.sw;
    s2_d.pass      = s1_q.pass;
    s2_d.pass_word = s1_q.pass_word;
    s2_d.sign      = s1_q.sign;
    s2_d.le        = s1_q.le;
    s2_d.acc       = acc;
    s2_d.found     = |acc;
    s2_d.top       = '0;
    for (int i = 0; i < 27; i++) begin
      if (acc[i]) s2_d.top = 5'(i);
    end
  end

  // stage 3: normalise, round, pack
  fas_round u_round (.n_i(s2_q), .word_o(s3_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign sum_bits_o  = s3_q;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sum_bits_o))
    else $error("result changed under stall");
  // full pipe stalled blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted into full pipe");
  // accepted beat lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("beat lost at stage 1");

endmodule

// File: sv/fas_round.sv
// ---------------------------------------------------------------------------
// fas_round
// Normalise, round half-up on one bit and pack the result word.
// ---------------------------------------------------------------------------
module fas_round (
  input  fas_pkg::norm_t n_i,
  output logic [31:0]    word_o
);

  logic [25:0] mant;
  logic [5:0]  ttop;
  logic [8:0]  e;
  logic [8:0]  k;
  logic [22:0] frac;
  logic [7:0]  ecl;

  always_comb begin
    mant = '0;
    if (n_i.found) begin
      if (n_i.top >= 5'd24) begin
        mant = 26'(n_i.acc >> (n_i.top - 5'd23))
             + 26'((n_i.acc >> (n_i.top - 5'd24)) & 27'd1);
      end else begin
        mant = 26'(n_i.acc << (5'd23 - n_i.top));
      end
    end
    ttop = {1'b0, n_i.top} + 6'(mant[25:24]);
    e    = '0;
    k    = '0;
    if (n_i.found) begin
      if (n_i.top >= 5'd25) begin
        k = 9'(ttop) - 9'd25;
        e = ((9'(fas_pkg::ExpMax) - 9'(n_i.le)) > k) ? 9'(n_i.le) + k
                                                     : 9'(fas_pkg::ExpMax);
      end else begin
        k = 9'd25 - 9'(ttop);
        e = (9'(n_i.le) > k) ? 9'(n_i.le) - k : 9'd0;
      end
    end
    ecl  = e[7:0];
    frac = (ecl == 8'd0 || ecl == fas_pkg::ExpMax) ? '0 : mant[22:0];
    word_o = n_i.pass ? n_i.pass_word : {n_i.sign, ecl, frac};
  end

endmodule
